FILE: rtl/sliding_window_slope_vario_unit_defines.svh
// ----------------------------------------------------------------------------
// Sliding window slope vario: assertion macros
// Shared property shapes for the concurrent checks of the vario unit.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_SLOPE_VARIO_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_SLOPE_VARIO_UNIT_DEFINES_SVH

// same-cycle implication
`define SWSV_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("swsv check failed");

// next-cycle implication
`define SWSV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("swsv check failed");

`endif

FILE: rtl/swsv_pkg.sv
// ----------------------------------------------------------------------------
// swsv_pkg
// Types and constants of the sliding window slope vario unit.
// ----------------------------------------------------------------------------
package swsv_pkg;

   localparam int ALT_W           = 21;
   localparam int TIME_W          = 32;
   localparam int SPEED_W         = 16;
   localparam int WIN_W           = 6;
   localparam int WIN_RESET       = 8;
   localparam int MAX_SAMPLES_DEF = 32;

   // relative time clamp
   localparam int TREL_W = 24;

   // 2000 = 2048 - 32 - 16, slope doubled for rounding
   localparam int SCALE_SH_HI  = 11;
   localparam int SCALE_SH_MID = 5;
   localparam int SCALE_SH_LO  = 4;

   // quotient bits before the result saturates anyway
   localparam int QUO_BITS = 17;

   typedef struct packed {
      logic signed [ALT_W-1:0] altitude_cm;
      logic [TIME_W-1:0]       time_ms;
   } req_word_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] vertical_speed_cm_s;
      logic                      speed_valid;
   } rsp_word_type;

endpackage

FILE: rtl/swsv_ram.sv
// ----------------------------------------------------------------------------
// swsv_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module swsv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/sliding_window_slope_vario_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_slope_vario_unit
// Least-squares vertical speed over the newest samples of an altitude ring.
// ----------------------------------------------------------------------------
// Each accepted word stores one altitude/time sample in the ring and returns
// one slope word in cm/s. The walk over the ring runs one read and three
// products per sample through a single shared multiplier, and the scaled
// division retires one quotient bit per cycle in a 17-step restoring loop.
// The input stalls while an item is in work; a finished word waits in the
// output register without holding off the next input. No clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
`include "sliding_window_slope_vario_unit_defines.svh"

module sliding_window_slope_vario_unit #(
   parameter int MAX_SAMPLES = swsv_pkg::MAX_SAMPLES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  swsv_pkg::req_word_type     req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output swsv_pkg::rsp_word_type     rsp_data,
   input  logic                       csr_wr_en,
   input  logic [swsv_pkg::WIN_W-1:0] csr_wr_data
);

   import swsv_pkg::*;

   localparam int AW    = $clog2(MAX_SAMPLES);
   localparam int CW    = $clog2(MAX_SAMPLES + 1);
   localparam int OW    = CW + 1;
   localparam int CMPW  = (CW > WIN_W) ? CW : WIN_W;
   localparam int TCW   = TREL_W + CW;
   localparam int SAW   = ALT_W + CW;
   localparam int MW    = TCW + 1;
   localparam int PW    = 2 * MW;
   localparam int DIVW  = PW + QUO_BITS + 1;
   localparam int KW    = $clog2(QUO_BITS);
   localparam int RAMW  = ALT_W + TIME_W;
   localparam int QW    = QUO_BITS + 1;

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_WAIT  = 13'b0000000000010,
      S_LOAD  = 13'b0000000000100,
      S_MNT   = 13'b0000000001000,
      S_MTT   = 13'b0000000010000,
      S_MTA   = 13'b0000000100000,
      S_MSS   = 13'b0000001000000,
      S_MSA   = 13'b0000010000000,
      S_ABS   = 13'b0000100000000,
      S_SCALE = 13'b0001000000000,
      S_OVF   = 13'b0010000000000,
      S_DIV   = 13'b0100000000000,
      S_DONE  = 13'b1000000000000
   } state_type;

   // control
   state_type        state_ff, state_in;
   logic [AW-1:0]    wp_ff, wp_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIN_W-1:0] window_ff, window_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]    left_ff, left_in;
   logic [KW-1:0]    k_ff, k_in;

   // datapath
   logic [AW-1:0]           rd_addr_ff, rd_addr_in;
   logic [CW-1:0]           n_ff, n_in;
   logic                    first_ff, first_in;
   logic [TIME_W-1:0]       t0_ff, t0_in;
   logic [TREL_W-1:0]       t_ff, t_in;
   logic signed [ALT_W-1:0] a_ff, a_in;
   logic [TCW-1:0]          nt_ff, nt_in;
   logic [TCW-1:0]          sum_t_ff, sum_t_in;
   logic signed [SAW-1:0]   sum_a_ff, sum_a_in;
   logic signed [PW-1:0]    acc_tt_ff, acc_tt_in;
   logic signed [PW-1:0]    acc_ta_ff, acc_ta_in;
   logic [PW-1:0]           mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic                    inval_ff, inval_in;
   logic [DIVW-1:0]         rem_ff, rem_in;
   logic                    big_ff, big_in;
   logic [QUO_BITS-1:0]     q_ff, q_in;
   rsp_word_type            rsp_data_ff, rsp_data_in;

   // ring and shared multiplier
   logic [RAMW-1:0]         rd_data;
   logic [TIME_W-1:0]       rd_time;
   logic signed [ALT_W-1:0] rd_alt;
   logic [TIME_W-1:0]       t_diff;
   logic [TREL_W-1:0]       trel;
   logic signed [MW-1:0]    mul_a, mul_b;
   logic signed [PW-1:0]    prod;

   // accept-time helpers
   logic            accept;
   logic [CW-1:0]   cnt_next;
   logic [AW-1:0]   wp_next;
   logic [CMPW-1:0] win_ext, cnt_ext;
   logic [CW-1:0]   n_calc;
   logic [OW-1:0]   wp_x, n_x;
   logic [AW-1:0]   oldest;
   logic [AW-1:0]   rd_addr_next;

   // division and rounding helpers
   logic [DIVW-1:0] div_shift;
   logic [QW-1:0]   q2;
   logic [QW:0]     q2_inc;
   logic [QW-1:0]   q_rnd;
   logic [SPEED_W-1:0] speed;
   logic            out_free;

   swsv_ram #(
      .WIDTH (RAMW),
      .DEPTH (MAX_SAMPLES)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wp_ff),
      .wr_data ({req_data.altitude_cm, req_data.time_ms}),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   assign rd_time = rd_data[TIME_W-1:0];
   assign rd_alt  = rd_data[RAMW-1:TIME_W];

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // window size and oldest slot after this sample is written
   always_comb begin
      cnt_next = (cnt_ff == CW'(MAX_SAMPLES)) ? cnt_ff : cnt_ff + 1'b1;
      wp_next  = (wp_ff == AW'(MAX_SAMPLES - 1)) ? '0 : wp_ff + 1'b1;
      win_ext  = CMPW'(window_ff);
      cnt_ext  = CMPW'(cnt_next);
      n_calc   = CW'((win_ext < cnt_ext) ? win_ext : cnt_ext);
      wp_x     = OW'(wp_next);
      n_x      = OW'(n_calc);
      oldest   = (wp_x >= n_x) ? AW'(wp_x - n_x) : AW'(wp_x + OW'(MAX_SAMPLES) - n_x);
      rd_addr_next = (rd_addr_ff == AW'(MAX_SAMPLES - 1)) ? '0 : rd_addr_ff + 1'b1;
   end

   // relative time, clamped to the 24-bit range
   always_comb begin
      t_diff = rd_time - t0_ff;
      if (first_ff) begin
         trel = '0;
      end else if (|t_diff[TIME_W-1:TREL_W]) begin
         trel = '1;
      end else begin
         trel = t_diff[TREL_W-1:0];
      end
   end

   always_comb begin
      unique case (state_ff)
         S_MNT: begin
            mul_a = MW'(n_ff);
            mul_b = MW'(t_ff);
         end
         S_MTT: begin
            mul_a = MW'(nt_ff);
            mul_b = MW'(t_ff);
         end
         S_MTA: begin
            mul_a = MW'(nt_ff);
            mul_b = MW'(a_ff);
         end
         S_MSS: begin
            mul_a = MW'(sum_t_ff);
            mul_b = MW'(sum_t_ff);
         end
         S_MSA: begin
            mul_a = MW'(sum_t_ff);
            mul_b = MW'(sum_a_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod = mul_a * mul_b;
   end

   // final rounding and saturation
   always_comb begin
      div_shift = DIVW'(acc_tt_ff) << k_ff;
      q2        = big_ff ? QW'(1) << QUO_BITS : QW'(q_ff);
      q2_inc    = (QW + 1)'(q2) + 1'b1;
      q_rnd     = q2_inc[QW:1];
      if (neg_ff) begin
         speed = (q_rnd > QW'(32768)) ? SPEED_W'(16'h8000) : SPEED_W'(~q_rnd + 1'b1);
      end else begin
         speed = (q_rnd > QW'(32767)) ? SPEED_W'(16'h7fff) : SPEED_W'(q_rnd);
      end
   end

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      cnt_in       = cnt_ff;
      window_in    = window_ff;
      rsp_valid_in = rsp_valid_ff;
      left_in      = left_ff;
      k_in         = k_ff;
      rd_addr_in   = rd_addr_ff;
      n_in         = n_ff;
      first_in     = first_ff;
      t0_in        = t0_ff;
      t_in         = t_ff;
      a_in         = a_ff;
      nt_in        = nt_ff;
      sum_t_in     = sum_t_ff;
      sum_a_in     = sum_a_ff;
      acc_tt_in    = acc_tt_ff;
      acc_ta_in    = acc_ta_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      inval_in     = inval_ff;
      rem_in       = rem_ff;
      big_in       = big_ff;
      q_in         = q_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_wr_en) begin
         window_in = csr_wr_data;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               wp_in      = wp_next;
               cnt_in     = cnt_next;
               n_in       = n_calc;
               left_in    = n_calc;
               rd_addr_in = oldest;
               first_in   = 1'b1;
               sum_t_in   = '0;
               sum_a_in   = '0;
               acc_tt_in  = '0;
               acc_ta_in  = '0;
               neg_in     = 1'b0;
               big_in     = 1'b0;
               q_in       = '0;
               inval_in   = (n_calc < CW'(2));
               state_in   = (n_calc < CW'(2)) ? S_DONE : S_WAIT;
            end
         end
         S_WAIT: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (first_ff) begin
               t0_in = rd_time;
            end
            t_in       = trel;
            a_in       = rd_alt;
            sum_t_in   = sum_t_ff + TCW'(trel);
            sum_a_in   = sum_a_ff + SAW'(rd_alt);
            first_in   = 1'b0;
            left_in    = left_ff - 1'b1;
            rd_addr_in = rd_addr_next;
            state_in   = S_MNT;
         end
         S_MNT: begin
            nt_in    = prod[TCW-1:0];
            state_in = S_MTT;
         end
         S_MTT: begin
            acc_tt_in = acc_tt_ff + prod;
            state_in  = S_MTA;
         end
         S_MTA: begin
            acc_ta_in = acc_ta_ff + prod;
            state_in  = (left_ff == '0) ? S_MSS : S_LOAD;
         end
         S_MSS: begin
            // denominator: n*sum(t^2) - sum(t)^2
            acc_tt_in = acc_tt_ff - prod;
            state_in  = S_MSA;
         end
         S_MSA: begin
            // numerator: n*sum(t*a) - sum(t)*sum(a)
            acc_ta_in = acc_ta_ff - prod;
            state_in  = S_ABS;
         end
         S_ABS: begin
            neg_in   = acc_ta_ff[PW-1];
            mag_in   = acc_ta_ff[PW-1] ? PW'(-acc_ta_ff) : PW'(acc_ta_ff);
            inval_in = (acc_tt_ff == '0);
            state_in = (acc_tt_ff == '0) ? S_DONE : S_SCALE;
         end
         S_SCALE: begin
            rem_in   = (DIVW'(mag_ff) << SCALE_SH_HI) - (DIVW'(mag_ff) << SCALE_SH_MID)
                       - (DIVW'(mag_ff) << SCALE_SH_LO);
            state_in = S_OVF;
         end
         S_OVF: begin
            // quotient too big for 17 bits: result saturates
            big_in   = (rem_ff >= (DIVW'(acc_tt_ff) << QUO_BITS));
            k_in     = KW'(QUO_BITS - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            if (rem_ff >= div_shift) begin
               rem_in = rem_ff - div_shift;
               q_in   = {q_ff[QUO_BITS-2:0], 1'b1};
            end else begin
               q_in   = {q_ff[QUO_BITS-2:0], 1'b0};
            end
            k_in = k_ff - 1'b1;
            if (k_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output word is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.vertical_speed_cm_s = inval_ff ? '0 : speed;
               rsp_data_in.speed_valid         = !inval_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         cnt_ff       <= '0;
         window_ff    <= WIN_W'(WIN_RESET);
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         cnt_ff       <= cnt_in;
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
         left_ff      <= left_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      n_ff        <= n_in;
      first_ff    <= first_in;
      t0_ff       <= t0_in;
      t_ff        <= t_in;
      a_ff        <= a_in;
      nt_ff       <= nt_in;
      sum_t_ff    <= sum_t_in;
      sum_a_ff    <= sum_a_in;
      acc_tt_ff   <= acc_tt_in;
      acc_ta_ff   <= acc_ta_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      inval_ff    <= inval_in;
      rem_ff      <= rem_in;
      big_ff      <= big_in;
      q_ff        <= q_in;
      rsp_data_ff <= rsp_data_in;
   end

   `SWSV_ASSERT_NEXT(a_accept_leaves_idle, accept, state_ff != S_IDLE)
   `SWSV_ASSERT_NOW(a_rsp_from_done, rsp_valid_ff && !$past(rsp_valid_ff), $past(state_ff == S_DONE))
   `SWSV_ASSERT_NOW(a_load_has_sample, state_ff == S_LOAD, left_ff != '0)

endmodule

FILE: tb/sv/tb_sliding_window_slope_vario_unit.sv
// ----------------------------------------------------------------------------
// Sliding window slope vario testbench
// Feeds altitude/time words through the vario unit under several window
// lengths and handshake patterns. The scoreboard fits the same least-squares
// line over its own copy of the ring and checks each slope word in order.
// ----------------------------------------------------------------------------
module tb_sliding_window_slope_vario_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import swsv_pkg::*;

   localparam int DEPTH     = MAX_SAMPLES_DEF;
   localparam int TREL_MAX  = (1 << TREL_W) - 1;
   localparam int SETTLE    = 200;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   class slope_scoreboard;
      logic signed [ALT_W-1:0] alt_ring[DEPTH];
      logic [TIME_W-1:0]       time_ring[DEPTH];
      int                      wr_ptr;
      int                      stored;
      logic [WIN_W-1:0]        window;
      rsp_word_type            slope_q[$];
      int                      errors;

      function new();
         wr_ptr = 0;
         stored = 0;
         window = WIN_W'(WIN_RESET);
         errors = 0;
      endfunction

      function void set_window(logic [WIN_W-1:0] w);
         window = w;
      endfunction

      // store the sample and queue the slope it yields
      function void note_sample(req_word_type w);
         rsp_word_type      r;
         int                n, oldest, idx;
         logic [TIME_W-1:0] t0, t;
         longint unsigned   sum_t, sum_tt, denom, mag;
         longint            sum_a, sum_ta, num;
         logic [127:0]      q2;
         logic [127:0]      q;
         alt_ring[wr_ptr] = w.altitude_cm;
         time_ring[wr_ptr] = w.time_ms;
         wr_ptr = (wr_ptr + 1) % DEPTH;
         if (stored < DEPTH) stored++;
         n = (stored < int'(window)) ? stored : int'(window);
         r = '0;
         if (n >= 2) begin
            oldest = (wr_ptr + DEPTH - n) % DEPTH;
            t0 = time_ring[oldest];
            sum_t = 0; sum_tt = 0; sum_a = 0; sum_ta = 0;
            for (int i = 0; i < n; i++) begin
               idx = (oldest + i) % DEPTH;
               t = time_ring[idx] - t0;
               if (t > TREL_MAX) t = TREL_MAX;
               sum_t += t;
               sum_tt += longint'(t) * longint'(t);
               sum_a += longint'(alt_ring[idx]);
               sum_ta += longint'(t) * longint'(alt_ring[idx]);
            end
            denom = longint'(n) * sum_tt - sum_t * sum_t;
            if (denom != 0) begin
               num = longint'(n) * sum_ta - longint'(sum_t) * sum_a;
               mag = (num < 0) ? -num : num;
               q2 = ({64'd0, mag} * 128'd2000) / {64'd0, denom};
               q = (q2 + 1) >> 1;
               if (num < 0)
                  r.vertical_speed_cm_s = (q > 32768) ? -16'sd32768 : -q[15:0];
               else
                  r.vertical_speed_cm_s = (q > 32767) ? 16'sd32767 : q[15:0];
               r.speed_valid = 1'b1;
            end
         end
         slope_q.push_back(r);
      endfunction

      function void check_slope(rsp_word_type got);
         rsp_word_type exp_w;
         if (slope_q.size() == 0) begin
            $display("%0t: unexpected slope word %0d/%0b", $realtime,
                     got.vertical_speed_cm_s, got.speed_valid);
            errors++;
            return;
         end
         exp_w = slope_q.pop_front();
         if (got.vertical_speed_cm_s !== exp_w.vertical_speed_cm_s) begin
            $display("%0t: speed expected %0d actual %0d", $realtime,
                     exp_w.vertical_speed_cm_s, got.vertical_speed_cm_s);
            errors++;
         end
         if (got.speed_valid !== exp_w.speed_valid) begin
            $display("%0t: valid expected %0b actual %0b", $realtime,
                     exp_w.speed_valid, got.speed_valid);
            errors++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_word_type     req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_word_type     rsp_data;
   logic             csr_wr_en;
   logic [WIN_W-1:0] csr_wr_data;

   slope_scoreboard  sb = new();
   idle_mode_type    idle_mode = IDLE_NONE;
   logic [TIME_W-1:0] last_time;
   int               alt_track;

   sliding_window_slope_vario_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver: check, then pick the stall for the next cycle
   initial rsp_stall = 1'b0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_slope(rsp_data);
         case (idle_mode)
            IDLE_RECV: rsp_stall <= ($urandom_range(99) < 68);
            IDLE_BOTH: rsp_stall <= ($urandom_range(99) < 9);
            default:   rsp_stall <= 1'b0;
         endcase
      end
   end

   task automatic send_word(req_word_type w);
      int gap;
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.note_sample(w);
      gap = 0;
      if (idle_mode == IDLE_SEND && $urandom_range(99) < 68) gap = $urandom_range(1, 12);
      if (idle_mode == IDLE_BOTH && $urandom_range(99) < 9) gap = $urandom_range(1, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_sample(int alt, logic [TIME_W-1:0] t);
      req_word_type w;
      w.altitude_cm = ALT_W'(alt);
      w.time_ms = t;
      last_time = t;
      send_word(w);
   endtask

   // hold off until every slope word is back and the unit is quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.slope_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_window(logic [WIN_W-1:0] w);
      csr_wr_en <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      sb.set_window(w);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // mostly a smooth climb or sink with small time steps, plus odd cases
   task automatic send_random();
      int                sel, alt;
      logic [TIME_W-1:0] t;
      sel = $urandom_range(99);
      if (sel < 4) t = last_time;
      else if (sel < 7) t = last_time + $urandom_range(32'h0100_0000, 32'h7fff_ffff);
      else if (sel < 9) t = $urandom;
      else t = last_time + $urandom_range(1, 300);
      sel = $urandom_range(99);
      if (sel < 6) alt = $urandom_range(1, 0) ? -1048576 : 1048575;
      else if (sel < 12) alt = $signed($urandom_range(0, 32'h1f_ffff) << 11) >>> 11;
      else begin
         alt_track += $signed($urandom_range(0, 4000)) - 2000;
         if (alt_track > 1048575) alt_track = 1048575;
         if (alt_track < -1048576) alt_track = -1048576;
         alt = alt_track;
      end
      send_sample(alt, t);
   endtask

   initial begin
      logic [WIN_W-1:0] windows[10] = '{6'd32, 6'd0, 6'd1, 6'd2, 6'd63,
                                        6'd33, 6'd5, 6'd16, 6'd32, 6'd8};
      int stage;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      last_time = 32'hffff_ff00;
      alt_track = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset window, first samples, extremes, flat, wrap, clamp
      send_sample(0, 32'hffff_ff00);
      send_sample(1048575, 32'hffff_ff00);
      send_sample(-1048576, 32'hffff_ff80);
      send_sample(1048575, 32'h0000_0010);
      send_sample(-1048576, 32'h0000_0011);
      send_sample(1048575, 32'h0000_0012);
      send_sample(-1048576, 32'h0000_0013);
      send_sample(1048575, 32'h0000_0014);
      send_sample(-1048576, 32'h0000_0015);
      send_sample(0, 32'h0000_0015);
      send_sample(1048575, 32'h8000_0000);
      send_sample(-1048576, 32'hffff_fffe);
      send_sample(12345, 32'h5555_5555);
      send_sample(-12345, 32'haaaa_aaaa);
      drain();
      write_window(6'd2);
      for (int i = 0; i < 4; i++) send_sample(100 * i, 32'h100);
      send_sample(1048575, 32'h101);
      send_sample(-1048576, 32'h102);
      send_sample(500, 32'h0200_0102);
      send_sample(-500, 32'h0400_0102);

      for (stage = 0; stage < 10; stage++) begin
         drain();
         write_window(windows[stage]);
         idle_mode = idle_mode_type'(stage % 4);
         for (int i = 0; i < 200; i++) send_random();
      end
      drain();
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/swsv_pkg.sv
rtl/swsv_ram.sv
rtl/sliding_window_slope_vario_unit.sv
tb/sv/tb_sliding_window_slope_vario_unit.sv
